// ===== hdl/ssg_pkg.sv =====
// ----------------------------------------------------------------------------
// ssg_pkg: shared types and constants of the stepper segment step generator
// Request codes, register indexes, field widths and the result item layout.
// ----------------------------------------------------------------------------
package ssg_pkg;

    // Field widths
    localparam int REQ_W     = 2;
    localparam int SEG_W     = 16;
    localparam int TPS_W     = 10;
    localparam int STEPS_W   = 8;
    localparam int POS_W     = 32;
    localparam int PEND_W    = 5;
    localparam int FRAC_BITS = 8;
    localparam int PROD_W    = TPS_W + SEG_W;
    localparam int CMP_W     = PROD_W - FRAC_BITS;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TPS_W;

    // Defaults
    localparam int                 QUEUE_DEPTH_DEF = 16;
    localparam logic [TPS_W-1:0]   TPS_RESET       = 10'd100;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ENQUEUE = 2'd0,
        REQ_TICK    = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_START   = 2'd3
    } t_req;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TPS     = 1'b0,
        CFG_DIR_INV = 1'b1
    } t_cfg_idx;

    // One result item
    typedef struct packed {
        logic                     step_pulse;
        logic                     dir_level;
        logic signed [POS_W-1:0]  position;
        logic [PEND_W-1:0]        pending_count;
        logic                     queue_full;
        logic                     moving_forward;
        logic                     moving_backward;
        logic                     enqueue_dropped;
    } t_out_item;

endpackage

// ===== hdl/ssg_in_if.sv =====
// ----------------------------------------------------------------------------
// ssg_in_if: request channel
// Valid/ready channel that carries one request item.
// ----------------------------------------------------------------------------
interface ssg_in_if;
    logic                              valid;
    logic                              ready;
    logic [ssg_pkg::REQ_W-1:0]         req_type;
    logic signed [ssg_pkg::SEG_W-1:0]  segment_steps;

    modport source (output valid, output req_type, output segment_steps, input ready);
    modport sink   (input valid, input req_type, input segment_steps, output ready);
endinterface

// ===== hdl/ssg_out_if.sv =====
// ----------------------------------------------------------------------------
// ssg_out_if: result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface ssg_out_if;
    logic                              valid;
    logic                              ready;
    logic                              step_pulse;
    logic                              dir_level;
    logic signed [ssg_pkg::POS_W-1:0]  position;
    logic [ssg_pkg::PEND_W-1:0]        pending_count;
    logic                              queue_full;
    logic                              moving_forward;
    logic                              moving_backward;
    logic                              enqueue_dropped;

    modport source (
        output valid, output step_pulse, output dir_level, output position,
        output pending_count, output queue_full, output moving_forward,
        output moving_backward, output enqueue_dropped, input ready
    );
    modport sink (
        input valid, input step_pulse, input dir_level, input position,
        input pending_count, input queue_full, input moving_forward,
        input moving_backward, input enqueue_dropped, output ready
    );
endinterface

// ===== hdl/stepper_segment_step_generator_unit.sv =====
// ----------------------------------------------------------------------------
// stepper_segment_step_generator_unit: one-channel stepper step generator
// Queues signed Q7.8 motion segments and turns timer ticks into step pulses.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries requests: enqueue a segment, tick, restart (drop the
//   active segment and the queue) or start (clear all state). Every request
//   gives exactly one result item on o_res with the pulse flag, direction
//   level, position, queue fill and motion flags after that request.
//   The configuration port writes the segment length in ticks (index 0) and
//   dir_invert (index 1); write it only while no request is in flight.
//   A request passes an input register, then the update that fills the result
//   register. Throughput is one request per cycle while o_res takes results;
//   the tick path has two short multipliers (tick by magnitude, steps by
//   ticks per segment) and a compare.
//   The segment queue is a RAM read at its head every cycle, so a segment
//   enqueued one request earlier is already visible to a tick.
//   When o_res stalls, the result register holds and the input register
//   takes one more request; after that i_req.ready drops.
//   Reset (synchronous, active low) empties the queue, clears the position
//   and loads a segment length of 100 ticks, dir_invert = 0.
// ----------------------------------------------------------------------------
module stepper_segment_step_generator_unit #(
    parameter int QUEUE_DEPTH = ssg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ssg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ssg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    ssg_in_if.sink                             i_req,
    ssg_out_if.source                          o_res
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = AW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(QUEUE_DEPTH - 1);

    // Configuration registers
    logic [ssg_pkg::TPS_W-1:0] r_tps;
    logic                      r_dir_inv;

    // Input register
    logic                              r_in_valid;
    ssg_pkg::t_req                     r_req;
    logic signed [ssg_pkg::SEG_W-1:0]  r_seg;

    // Channel state
    logic [CW-1:0]                       r_count, n_count;
    logic [AW-1:0]                       r_head, n_head;
    logic signed [ssg_pkg::SEG_W-1:0]    r_act, n_act;
    logic                                r_loaded, n_loaded;
    logic [ssg_pkg::TPS_W-1:0]           r_tick, n_tick;
    logic [ssg_pkg::STEPS_W-1:0]         r_steps, n_steps;
    logic signed [ssg_pkg::POS_W-1:0]    r_pos, n_pos;
    logic                                r_dir, n_dir;

    // Result register
    logic               r_out_valid;
    ssg_pkg::t_out_item r_out;

    // Head bypass for a write to the address being read
    logic                       r_byp_hit;
    logic [ssg_pkg::SEG_W-1:0]  r_byp_data;

    logic                                adv;
    logic                                pulse;
    logic                                dropped;
    logic                                loaded_mid;
    logic                                ram_we;
    logic [AW-1:0]                       wr_addr;
    logic [SW-1:0]                       tail_sum;
    logic [AW-1:0]                       head_inc;
    logic [ssg_pkg::SEG_W-1:0]           ram_rdata;
    logic [ssg_pkg::SEG_W-1:0]           head_data;
    logic [ssg_pkg::TPS_W-1:0]           tick_inc;
    logic [ssg_pkg::SEG_W-1:0]           seg_mag;
    logic [ssg_pkg::PROD_W-1:0]          prod_lhs;
    logic [ssg_pkg::CMP_W-1:0]           lhs;
    logic [ssg_pkg::CMP_W-1:0]           rhs;

    // Handshake: the update stage advances when the result register is free
    assign adv         = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || adv;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps     <= ssg_pkg::TPS_RESET;
            r_dir_inv <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (ssg_pkg::t_cfg_idx'(i_cfg_idx))
                ssg_pkg::CFG_TPS:     r_tps     <= i_cfg_data[ssg_pkg::TPS_W-1:0];
                ssg_pkg::CFG_DIR_INV: r_dir_inv <= i_cfg_data[0];
                default:              r_tps     <= r_tps;
            endcase
        end
    end

    // Capture the request item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_req <= ssg_pkg::t_req'(i_req.req_type);
            r_seg <= i_req.segment_steps;
        end
    end

    // Queue addressing: tail = (head + count) mod depth, head advance wraps
    assign tail_sum = {1'b0, r_head} + SW'(r_count);
    assign wr_addr  = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : tail_sum[AW-1:0];
    assign head_inc = (r_head == LAST_A) ? '0 : AW'(r_head + 1'b1);

    // Segment queue, read at the next head every cycle
    ssg_ram #(
        .WIDTH (ssg_pkg::SEG_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata (r_seg),
        .i_raddr (n_head),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else begin
            r_byp_hit <= ram_we && (wr_addr == n_head);
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= r_seg;
    end

    assign head_data = r_byp_hit ? r_byp_data : ram_rdata;

    // Step test: floor(tick * |segment| / 256) > steps * segment length
    assign tick_inc = r_tick + 1'b1;
    assign seg_mag  = r_act[ssg_pkg::SEG_W-1] ? ssg_pkg::SEG_W'(-r_act)
                                              : ssg_pkg::SEG_W'(r_act);
    assign prod_lhs = tick_inc * seg_mag;
    assign lhs      = prod_lhs[ssg_pkg::PROD_W-1:ssg_pkg::FRAC_BITS];
    assign rhs      = r_steps * r_tps;

    // Request decode and state update
    always_comb begin
        n_count    = r_count;
        n_head     = r_head;
        n_act      = r_act;
        n_loaded   = r_loaded;
        n_tick     = r_tick;
        n_steps    = r_steps;
        n_pos      = r_pos;
        n_dir      = r_dir;
        pulse      = 1'b0;
        dropped    = 1'b0;
        ram_we     = 1'b0;
        loaded_mid = r_loaded;
        if (adv) begin
            unique case (r_req)
                ssg_pkg::REQ_ENQUEUE: begin
                    if (r_count == DEPTH_C) begin
                        dropped = 1'b1;
                    end else begin
                        ram_we  = 1'b1;
                        n_count = CW'(r_count + 1'b1);
                    end
                end
                ssg_pkg::REQ_TICK: begin
                    // advance the active segment
                    if (r_loaded) begin
                        n_tick = tick_inc;
                        if (lhs > rhs) begin
                            pulse   = 1'b1;
                            n_steps = r_steps + 1'b1;
                        end
                        if (tick_inc >= r_tps) begin
                            if (r_act > 0) begin
                                n_pos = r_pos + ssg_pkg::POS_W'(n_steps);
                            end else begin
                                n_pos = r_pos - ssg_pkg::POS_W'(n_steps);
                            end
                            loaded_mid = 1'b0;
                        end
                    end
                    // load the next queued segment
                    if (!loaded_mid && r_count != '0) begin
                        n_act    = head_data;
                        n_head   = head_inc;
                        n_count  = CW'(r_count - 1'b1);
                        n_loaded = 1'b1;
                        n_steps  = '0;
                        n_tick   = '0;
                        n_dir    = head_data[ssg_pkg::SEG_W-1] ^ r_dir_inv;
                    end else begin
                        n_loaded = loaded_mid;
                    end
                end
                ssg_pkg::REQ_RESTART: begin
                    n_loaded = 1'b0;
                    n_dir    = 1'b0;
                    n_count  = '0;
                    n_head   = '0;
                end
                ssg_pkg::REQ_START: begin
                    n_count  = '0;
                    n_head   = '0;
                    n_act    = '0;
                    n_loaded = 1'b0;
                    n_tick   = '0;
                    n_steps  = '0;
                    n_pos    = '0;
                    n_dir    = 1'b0;
                end
                default: begin
                    n_loaded = r_loaded;
                end
            endcase
        end
    end

    // Hold the channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_head   <= '0;
            r_act    <= '0;
            r_loaded <= 1'b0;
            r_tick   <= '0;
            r_steps  <= '0;
            r_pos    <= '0;
            r_dir    <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_head   <= n_head;
            r_act    <= n_act;
            r_loaded <= n_loaded;
            r_tick   <= n_tick;
            r_steps  <= n_steps;
            r_pos    <= n_pos;
            r_dir    <= n_dir;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.step_pulse      <= pulse;
            r_out.dir_level       <= n_dir;
            r_out.position        <= n_pos;
            r_out.pending_count   <= ssg_pkg::PEND_W'(n_count);
            r_out.queue_full      <= (n_count == DEPTH_C);
            r_out.moving_forward  <= n_loaded && (n_act > 0);
            r_out.moving_backward <= n_loaded && (n_act < 0);
            r_out.enqueue_dropped <= dropped;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.step_pulse      = r_out.step_pulse;
    assign o_res.dir_level       = r_out.dir_level;
    assign o_res.position        = r_out.position;
    assign o_res.pending_count   = r_out.pending_count;
    assign o_res.queue_full      = r_out.queue_full;
    assign o_res.moving_forward  = r_out.moving_forward;
    assign o_res.moving_backward = r_out.moving_backward;
    assign o_res.enqueue_dropped = r_out.enqueue_dropped;

    // Queue fill never exceeds its depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("queue count above depth");

    // An accepted enqueue grows the queue by one
    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_req == ssg_pkg::REQ_ENQUEUE && r_count != DEPTH_C)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("enqueue did not grow the queue");

    // A dropped segment is only reported with a full queue
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.enqueue_dropped) |-> r_out.queue_full)
        else $error("drop reported with room in queue");

    // Pulses come only from a loaded segment
    a_pulse_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && pulse) |-> r_loaded)
        else $error("pulse without active segment");

    // Restart leaves the channel idle with direction cleared
    a_restart_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_req == ssg_pkg::REQ_RESTART) |=> (!r_loaded && !r_dir && r_count == '0))
        else $error("restart left channel active");

endmodule

// ===== hdl/ssg_ram.sv =====
// ----------------------------------------------------------------------------
// ssg_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module ssg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]          i_wdata,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
